[rtl/rrtt_pkg.sv]
`timescale 1ns / 1ps

package rrtt_pkg;

  // Transaction phase, also the status code on the result channel
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_CONF = 3'd1,
    PH_WAIT_RESP = 3'd2,
    PH_OK        = 3'd3,
    PH_ERROR     = 3'd4,
    PH_CONF_TMO  = 3'd5,
    PH_RESP_TMO  = 3'd6
  } phase_t;

  // Item modes
  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_CONF = 2'd1;
  localparam logic [1:0] MODE_RESP = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  // Timing constants (ms)
  localparam logic [15:0] DEFAULT_WAIT   = 16'd500;
  localparam logic [15:0] BROADCAST_ADDR = 16'h00FF;
  localparam logic [15:0] CONF_BASE      = 16'd60;
  localparam logic [7:0]  RHOP_MUL       = 8'd50;
  localparam logic [7:0]  SLOT_MUL       = 8'd10;
  localparam logic [7:0]  HOLD_MUL       = 8'd40;
  localparam logic [15:0] HOLD_BASE      = 16'd100;

  // Operands of the shared multiply-add unit: res = c + a * b (mod 2^16)
  typedef struct packed {
    logic [15:0] a;
    logic [7:0]  b;
    logic [15:0] c;
  } mac_op_t;

endpackage

[rtl/rrtt_if.sv]
`timescale 1ns / 1ps

// Request/answer/tick item channel
interface rrtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] node_addr;
  logic [15:0] preset_timeout;
  logic        confirm_valid;
  logic [7:0]  hop_count;
  logic [7:0]  slot_length;
  logic [7:0]  reply_hops;
  logic        response_ok;

  modport source (
    output valid, mode, node_addr, preset_timeout, confirm_valid,
           hop_count, slot_length, reply_hops, response_ok,
    input  ready
  );
  modport sink (
    input  valid, mode, node_addr, preset_timeout, confirm_valid,
           hop_count, slot_length, reply_hops, response_ok,
    output ready
  );
endinterface

// Status result channel
interface rrtt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        accepted;
  logic        finished;
  logic [15:0] timeout_left;
  logic [15:0] holdoff_left;

  modport source (
    output valid, status, accepted, finished, timeout_left, holdoff_left,
    input  ready
  );
  modport sink (
    input  valid, status, accepted, finished, timeout_left, holdoff_left,
    output ready
  );
endinterface

[rtl/request_response_timeout_tracker_core.sv]
`timescale 1ns / 1ps

// Timeout tracker for one outstanding mesh request. Each input transaction
// (request, confirmation, response or 1 ms tick) yields exactly one status
// result. Items are handled one at a time by a small sequencer around a
// single 16x8 multiply-add unit. A valid non-broadcast confirmation takes
// three passes through that unit to build the response wait
// (rhops*50+60, then (hops+1)*slot, then *10 plus the sum). The result
// is registered when the item's last step commits, and a new item can only
// be taken once the previous one has committed. in_ch.ready is low while an
// item is in work. An item waits at its last step while the previous result
// has not been taken. node_count is written through cfg_we/cfg_wdata and
// saturates at MAX_NODES.
module request_response_timeout_tracker_core #(
  parameter int MAX_NODES = 239
) (
  input  logic             clk,
  input  logic             rst_n,
  rrtt_in_if.sink          in_ch,
  rrtt_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  localparam logic [7:0] MaxNodesC = 8'(MAX_NODES);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  // Sequencer
  seq_state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  // Latched item
  logic [1:0]  mode_r;
  logic [15:0] addr_r;
  logic [15:0] preset_r;
  logic        cvalid_r;
  logic [7:0]  hops_r;
  logic [7:0]  slot_r;
  logic [7:0]  rhops_r;
  logic        rok_r;

  // Partial results of the multiply-add passes
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] tmp_r, tmp_nxt;

  // Tracker state
  rrtt_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [7:0]  node_cnt_r, node_cnt_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_acc_r, out_acc_nxt;
  logic        out_fin_r, out_fin_nxt;

  logic        waiting;
  logic        conf_path;
  logic        bcast;
  logic [1:0]  last_step;
  logic        commit;
  logic        item_take;
  logic        accepted_c;
  logic        finished_c;
  rrtt_pkg::mac_op_t mac_op;
  logic [15:0] mac_res;

  assign waiting   = (phase_r == rrtt_pkg::PH_WAIT_CONF) ||
                     (phase_r == rrtt_pkg::PH_WAIT_RESP);
  assign conf_path = (mode_r == rrtt_pkg::MODE_CONF) &&
                     (phase_r == rrtt_pkg::PH_WAIT_CONF) && cvalid_r;
  assign bcast     = (pend_r == rrtt_pkg::BROADCAST_ADDR);
  assign last_step = (conf_path && !bcast) ? 2'd2 : 2'd0;
  assign commit    = (state_r == S_RUN) && (step_r == last_step) &&
                     (!out_valid_r || out_ch.ready);
  assign item_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = phase_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.timeout_left = wait_r;
  assign out_ch.holdoff_left = hold_r;

  // Operand select per step
  always_comb begin
    mac_op = '{a: 16'd0, b: 8'd0, c: 16'd0};
    case (step_r)
      2'd0: begin
        if (conf_path && !bcast) begin
          mac_op = '{a: 16'(rhops_r), b: rrtt_pkg::RHOP_MUL, c: rrtt_pkg::CONF_BASE};
        end else if (mode_r == rrtt_pkg::MODE_RESP) begin
          if (addr_r != 16'd0) begin
            mac_op = '{a: 16'(node_cnt_r), b: rrtt_pkg::HOLD_MUL, c: 16'd0};
          end else begin
            mac_op = '{a: 16'd0, b: rrtt_pkg::HOLD_MUL, c: rrtt_pkg::HOLD_BASE};
          end
        end else begin
          // broadcast confirmation hold-off
          mac_op = '{a: 16'(node_cnt_r), b: rrtt_pkg::HOLD_MUL, c: rrtt_pkg::HOLD_BASE};
        end
      end
      2'd1: begin
        mac_op = '{a: 16'(hops_r) + 16'd1, b: slot_r, c: 16'd0};
      end
      default: begin
        mac_op = '{a: tmp_r, b: rrtt_pkg::SLOT_MUL, c: acc_r};
      end
    endcase
  end

  rrtt_mac u_mac (
    .op  (mac_op),
    .res (mac_res)
  );

  // Tracker update applied at commit
  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    wait_nxt   = wait_r;
    hold_nxt   = hold_r;
    accepted_c = 1'b0;
    finished_c = 1'b0;
    case (mode_r)
      rrtt_pkg::MODE_REQ: begin
        if (!waiting && (hold_r == 16'd0)) begin
          pend_nxt   = addr_r;
          phase_nxt  = (addr_r == 16'd0) ? rrtt_pkg::PH_WAIT_RESP : rrtt_pkg::PH_WAIT_CONF;
          wait_nxt   = (preset_r != 16'd0) ? preset_r : rrtt_pkg::DEFAULT_WAIT;
          accepted_c = 1'b1;
        end
      end
      rrtt_pkg::MODE_CONF: begin
        if (conf_path) begin
          if (!bcast) begin
            phase_nxt = rrtt_pkg::PH_WAIT_RESP;
            wait_nxt  = mac_res;
          end else begin
            phase_nxt  = rrtt_pkg::PH_OK;
            wait_nxt   = 16'd0;
            hold_nxt   = mac_res;
            finished_c = 1'b1;
          end
        end
      end
      rrtt_pkg::MODE_RESP: begin
        if (phase_r == rrtt_pkg::PH_WAIT_RESP) begin
          phase_nxt  = rok_r ? rrtt_pkg::PH_OK : rrtt_pkg::PH_ERROR;
          wait_nxt   = 16'd0;
          hold_nxt   = mac_res;
          finished_c = 1'b1;
        end
      end
      default: begin
        // millisecond tick; a zero wait never expires
        if (waiting && (wait_r != 16'd0)) begin
          wait_nxt = wait_r - 16'd1;
          if (wait_r == 16'd1) begin
            phase_nxt  = (phase_r == rrtt_pkg::PH_WAIT_CONF) ?
                         rrtt_pkg::PH_CONF_TMO : rrtt_pkg::PH_RESP_TMO;
            finished_c = 1'b1;
          end
        end
        if (hold_r != 16'd0) begin
          hold_nxt = hold_r - 16'd1;
        end
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_fin_nxt   = out_fin_r;
    node_cnt_nxt  = node_cnt_r;
    if (cfg_we) begin
      node_cnt_nxt = (cfg_wdata > MaxNodesC) ? MaxNodesC : cfg_wdata;
    end
    case (state_r)
      S_IDLE: begin
        if (item_take) begin
          state_nxt = S_RUN;
          step_nxt  = 2'd0;
        end
      end
      S_RUN: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_acc_nxt   = accepted_c;
          out_fin_nxt   = finished_c;
        end else if (step_r != last_step) begin
          step_nxt = step_r + 2'd1;
          if (step_r == 2'd0) begin
            acc_nxt = mac_res;
          end else begin
            tmp_nxt = mac_res;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 2'd0;
      phase_r     <= rrtt_pkg::PH_IDLE;
      pend_r      <= 16'd0;
      wait_r      <= 16'd0;
      hold_r      <= 16'd0;
      node_cnt_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      node_cnt_r  <= node_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      tmp_r       <= tmp_nxt;
      out_acc_r   <= out_acc_nxt;
      out_fin_r   <= out_fin_nxt;
      if (commit) begin
        phase_r <= phase_nxt;
        pend_r  <= pend_nxt;
        wait_r  <= wait_nxt;
        hold_r  <= hold_nxt;
      end
      if (item_take) begin
        mode_r   <= in_ch.mode;
        addr_r   <= in_ch.node_addr;
        preset_r <= in_ch.preset_timeout;
        cvalid_r <= in_ch.confirm_valid;
        hops_r   <= in_ch.hop_count;
        slot_r   <= in_ch.slot_length;
        rhops_r  <= in_ch.reply_hops;
        rok_r    <= in_ch.response_ok;
      end
    end
  end

endmodule

[rtl/rrtt_mac.sv]
`timescale 1ns / 1ps

// Shared 16x8 multiply-add, result wraps to 16 bits
module rrtt_mac (
  input  rrtt_pkg::mac_op_t op,
  output logic [15:0]       res
);

  logic [23:0] prod;

  assign prod = 24'(op.a) * 24'(op.b);
  assign res  = op.c + prod[15:0];

endmodule

[rtl/rrtt_checker.sv]
`timescale 1ns / 1ps

module rrtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_accepted,
  input logic        out_finished,
  input logic [15:0] out_timeout_left
);

  // A result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // One item in work at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction was taken");

  // A taken request always starts a wait
  a_accept_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |->
      (out_status == rrtt_pkg::PH_WAIT_CONF || out_status == rrtt_pkg::PH_WAIT_RESP))
    else $error("accepted request without a wait phase");

  // A finished transaction leaves no wait running
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> (out_timeout_left == 16'd0) && !out_accepted)
    else $error("finished transaction with wait left");

endmodule

bind request_response_timeout_tracker_core rrtt_checker u_rrtt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_accepted     (out_ch.accepted),
  .out_finished     (out_ch.finished),
  .out_timeout_left (out_ch.timeout_left)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Timing figures of the tracker, in ms
  localparam logic [15:0] WAIT_DEFAULT_MS = 16'd500;
  localparam logic [15:0] BCAST_DEST      = 16'h00FF;
  localparam logic [31:0] SLOT_SCALE      = 32'd10;
  localparam logic [31:0] RHOP_SCALE      = 32'd50;
  localparam logic [31:0] RESP_BASE_MS    = 32'd60;
  localparam logic [31:0] HOLD_SCALE      = 32'd40;
  localparam logic [31:0] HOLD_BASE_MS    = 32'd100;
  localparam int          NODE_CAP        = 239;

  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIRECTED  = 27;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] node_addr;
    logic [15:0] preset_timeout;
    logic        confirm_valid;
    logic [7:0]  hop_count;
    logic [7:0]  slot_length;
    logic [7:0]  reply_hops;
    logic        response_ok;
  } mesh_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        accepted;
    logic        finished;
    logic [15:0] timeout_left;
    logic [15:0] holdoff_left;
  } status_rec_t;

  typedef struct packed {
    mesh_item_t  item;
    bit          typed;
    status_rec_t want;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  rrtt_in_if  in_ch ();
  rrtt_out_if out_ch ();

  request_response_timeout_tracker_core #(
    .MAX_NODES (NODE_CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted tracker state
  rrtt_pkg::phase_t trk_phase = rrtt_pkg::PH_IDLE;
  logic [15:0] trk_dest = 16'd0;
  logic [15:0] trk_wait = 16'd0;
  logic [15:0] trk_hold = 16'd0;
  logic [7:0]  trk_nodes;

  status_rec_t expected_status [$];
  bit          typed_pending;
  status_rec_t typed_want;
  int          fail_count;
  int          quiet_cycles;
  int          burst_left;
  stim_row_t   directed_rows [NUM_DIRECTED];

  rx_style_t rx_style;
  int        rx_span;
  int        rx_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit tracker_waiting();
    return trk_phase == rrtt_pkg::PH_WAIT_CONF || trk_phase == rrtt_pkg::PH_WAIT_RESP;
  endfunction

  // Advance the predicted state by one transaction, return the status it yields
  function automatic status_rec_t track_item(input mesh_item_t it);
    status_rec_t r;
    logic [31:0] sum;
    r = '0;
    case (it.mode)
      rrtt_pkg::MODE_REQ: begin
        if (!tracker_waiting() && trk_hold == 16'd0) begin
          trk_dest = it.node_addr;
          trk_phase = (it.node_addr == 16'd0) ? rrtt_pkg::PH_WAIT_RESP
                                              : rrtt_pkg::PH_WAIT_CONF;
          trk_wait = (it.preset_timeout != 16'd0) ? it.preset_timeout : WAIT_DEFAULT_MS;
          r.accepted = 1'b1;
        end
      end
      rrtt_pkg::MODE_CONF: begin
        if (trk_phase == rrtt_pkg::PH_WAIT_CONF && it.confirm_valid) begin
          if (trk_dest != BCAST_DEST) begin
            trk_phase = rrtt_pkg::PH_WAIT_RESP;
            sum = ({24'd0, it.hop_count} + 32'd1) * {24'd0, it.slot_length} * SLOT_SCALE
                  + {24'd0, it.reply_hops} * RHOP_SCALE + RESP_BASE_MS;
            trk_wait = sum[15:0];
          end else begin
            // broadcast needs no response
            trk_phase = rrtt_pkg::PH_OK;
            trk_wait = 16'd0;
            sum = {24'd0, trk_nodes} * HOLD_SCALE + HOLD_BASE_MS;
            trk_hold = sum[15:0];
            r.finished = 1'b1;
          end
        end
      end
      rrtt_pkg::MODE_RESP: begin
        if (trk_phase == rrtt_pkg::PH_WAIT_RESP) begin
          trk_phase = it.response_ok ? rrtt_pkg::PH_OK : rrtt_pkg::PH_ERROR;
          trk_wait = 16'd0;
          sum = (it.node_addr != 16'd0) ? {24'd0, trk_nodes} * HOLD_SCALE : HOLD_BASE_MS;
          trk_hold = sum[15:0];
          r.finished = 1'b1;
        end
      end
      rrtt_pkg::MODE_TICK: begin
        // a zero wait never counts down
        if (tracker_waiting() && trk_wait != 16'd0) begin
          trk_wait = trk_wait - 16'd1;
          if (trk_wait == 16'd0) begin
            trk_phase = (trk_phase == rrtt_pkg::PH_WAIT_CONF) ? rrtt_pkg::PH_CONF_TMO
                                                               : rrtt_pkg::PH_RESP_TMO;
            r.finished = 1'b1;
          end
        end
        if (trk_hold != 16'd0)
          trk_hold = trk_hold - 16'd1;
      end
      default: begin
      end
    endcase
    r.status = trk_phase;
    r.timeout_left = trk_wait;
    r.holdoff_left = trk_hold;
    return r;
  endfunction

  function automatic stim_row_t dir_row(
    input logic [1:0] m, input logic [15:0] a, input logic [15:0] p, input logic cv,
    input logic [7:0] h, input logic [7:0] s, input logic [7:0] rh, input logic ok,
    input bit typed, input rrtt_pkg::phase_t st, input logic acc, input logic fin,
    input logic [15:0] tl, input logic [15:0] hl);
    stim_row_t row;
    row.item = '{m, a, p, cv, h, s, rh, ok};
    row.typed = typed;
    row.want = '{st, acc, fin, tl, hl};
    return row;
  endfunction

  // Random transaction steered by the predicted state
  function automatic mesh_item_t pick_item();
    mesh_item_t it;
    int roll;
    int sel;
    it.mode = 2'($urandom_range(0, 3));
    it.node_addr = 16'($urandom_range(0, 65535));
    it.preset_timeout = 16'($urandom_range(0, 65535));
    it.confirm_valid = 1'($urandom_range(0, 1));
    it.hop_count = 8'($urandom_range(0, 255));
    it.slot_length = 8'($urandom_range(0, 255));
    it.reply_hops = 8'($urandom_range(0, 255));
    it.response_ok = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (!tracker_waiting() && trk_hold != 16'd0) begin
      if (roll < 85)
        it.mode = rrtt_pkg::MODE_TICK;
    end else if (!tracker_waiting()) begin
      if (roll < 80) begin
        it.mode = rrtt_pkg::MODE_REQ;
        if (sel < 20)
          it.node_addr = 16'd0;
        else if (sel < 40)
          it.node_addr = BCAST_DEST;
        sel = $urandom_range(0, 99);
        if (sel < 15)
          it.preset_timeout = 16'd0;
        else if (sel < 60)
          it.preset_timeout = 16'($urandom_range(1, 6));
        else if (sel < 85)
          it.preset_timeout = 16'($urandom_range(7, 40));
      end
    end else if (trk_phase == rrtt_pkg::PH_WAIT_CONF) begin
      if (roll < 50) begin
        it.mode = rrtt_pkg::MODE_CONF;
        it.confirm_valid = 1'b1;
        if (sel < 70) begin
          it.hop_count = 8'($urandom_range(0, 3));
          it.slot_length = 8'($urandom_range(0, 3));
          it.reply_hops = 8'($urandom_range(0, 3));
        end
      end else if (roll < 80) begin
        it.mode = rrtt_pkg::MODE_TICK;
      end
    end else begin
      if (roll < 45) begin
        it.mode = rrtt_pkg::MODE_RESP;
        if (sel < 30)
          it.node_addr = 16'd0;
      end else if (roll < 85) begin
        it.mode = rrtt_pkg::MODE_TICK;
      end
    end
    return it;
  endfunction

  task automatic note_failure(input string what, input status_rec_t want,
                              input status_rec_t seen);
    fail_count = fail_count + 1;
    if (fail_count <= MAX_REPORTS)
      $display("%0t %s: exp st=%0d acc=%0d fin=%0d tmo=%0d hold=%0d",
               $time, what, want.status, want.accepted, want.finished, want.timeout_left,
               want.holdoff_left,
               " | got st=%0d acc=%0d fin=%0d tmo=%0d hold=%0d",
               seen.status, seen.accepted, seen.finished,
               seen.timeout_left, seen.holdoff_left);
  endtask

  // Present one transaction and hold it until taken; returns at a falling edge
  task automatic send_item(input mesh_item_t it, input bit typed, input status_rec_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_ch.mode = it.mode;
    in_ch.node_addr = it.node_addr;
    in_ch.preset_timeout = it.preset_timeout;
    in_ch.confirm_valid = it.confirm_valid;
    in_ch.hop_count = it.hop_count;
    in_ch.slot_length = it.slot_length;
    in_ch.reply_hops = it.reply_hops;
    in_ch.response_ok = it.response_ok;
    in_ch.valid = 1'b1;
    typed_pending = typed;
    typed_want = want;
    @(posedge clk);
    while (in_ch.ready !== 1'b1)
      @(posedge clk);
    @(negedge clk);
    burst_left = burst_left - 1;
  endtask

  // Stop sending and let every outstanding status come back
  task automatic drain_results();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_node_count(input logic [7:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    trk_nodes = (value > NODE_CAP) ? 8'(NODE_CAP) : value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver back-pressure, switching style every so often
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_span = $urandom_range(16, 160);
    end
    rx_span = rx_span - 1;
    rx_count = rx_count + 1;
    case (rx_style)
      RX_OPEN:     out_ch.ready = 1'b1;
      RX_COIN:     out_ch.ready = 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ch.ready = (rx_count % 5) != 0;
      default:     out_ch.ready = ($urandom_range(0, 9) < 2);
    endcase
  end

  // Predict on each accepted transaction, check each returned status
  always @(posedge clk) begin : monitor
    mesh_item_t  got;
    status_rec_t want;
    status_rec_t seen;
    bit          took_in;
    bit          took_out;
    took_in = rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
    took_out = rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1;
    if (took_in) begin
      got = '{in_ch.mode, in_ch.node_addr, in_ch.preset_timeout, in_ch.confirm_valid,
              in_ch.hop_count, in_ch.slot_length, in_ch.reply_hops, in_ch.response_ok};
      want = track_item(got);
      if (typed_pending)
        want = typed_want;
      expected_status.push_back(want);
    end
    if (took_out) begin
      seen = '{out_ch.status, out_ch.accepted, out_ch.finished, out_ch.timeout_left,
               out_ch.holdoff_left};
      if (expected_status.size() == 0) begin
        note_failure("status with nothing expected", '0, seen);
      end else begin
        want = expected_status.pop_front();
        if (seen.status !== want.status || seen.accepted !== want.accepted ||
            seen.finished !== want.finished || seen.timeout_left !== want.timeout_left ||
            seen.holdoff_left !== want.holdoff_left)
          note_failure("status mismatch", want, seen);
      end
    end
    quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
  end

  // Watchdog on handshake activity
  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    logic [7:0] node_plan [NUM_PHASES];
    int         budget [NUM_PHASES];
    int         phase_sent;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.mode = rrtt_pkg::MODE_TICK;
    in_ch.node_addr = 16'd0;
    in_ch.preset_timeout = 16'd0;
    in_ch.confirm_valid = 1'b0;
    in_ch.hop_count = 8'd0;
    in_ch.slot_length = 8'd0;
    in_ch.reply_hops = 8'd0;
    in_ch.response_ok = 1'b0;
    trk_nodes = 8'd0;
    typed_pending = 1'b0;
    typed_want = '0;
    burst_left = 0;

    // Directed rows; typed expectations assume node_count 0
    directed_rows = '{
      // stray items on an idle tracker
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 1, 8'd255, 8'd255, 8'd255, 0,
              1, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_RESP, 16'hFFFF, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 1,
              1, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0),
      // coordinator request with default wait, then busy and stray items
      dir_row(rrtt_pkg::MODE_REQ, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 1, 0, 16'd500, 16'd0),
      dir_row(rrtt_pkg::MODE_REQ, 16'h1234, 16'h0007, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd500, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 1, 8'd1, 8'd1, 8'd1, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd500, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd499, 16'd0),
      dir_row(rrtt_pkg::MODE_RESP, 16'hFFFF, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_ERROR, 0, 1, 16'd0, 16'd0),
      // largest preset, invalid confirmation, early response, widest figures
      dir_row(rrtt_pkg::MODE_REQ, 16'hFFFF, 16'hFFFF, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_CONF, 1, 0, 16'd65535, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 0, 8'd255, 8'd255, 8'd255, 0,
              1, rrtt_pkg::PH_WAIT_CONF, 0, 0, 16'd65535, 16'd0),
      dir_row(rrtt_pkg::MODE_RESP, 16'h0001, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 1,
              1, rrtt_pkg::PH_WAIT_CONF, 0, 0, 16'd65535, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 1, 8'd255, 8'd255, 8'd255, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd10250, 16'd0),
      dir_row(rrtt_pkg::MODE_RESP, 16'h0001, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 1,
              1, rrtt_pkg::PH_OK, 0, 1, 16'd0, 16'd0),
      // response timeout
      dir_row(rrtt_pkg::MODE_REQ, 16'h0000, 16'h0001, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 1, 0, 16'd1, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_RESP_TMO, 0, 1, 16'd0, 16'd0),
      // confirmation timeout, then a tick that changes nothing
      dir_row(rrtt_pkg::MODE_REQ, 16'h00FF, 16'h0002, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_CONF, 1, 0, 16'd2, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              0, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_CONF_TMO, 0, 1, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_CONF_TMO, 0, 0, 16'd0, 16'd0),
      // response wait that wraps to zero never expires
      dir_row(rrtt_pkg::MODE_REQ, 16'h8000, 16'h0001, 0, 8'd0, 8'd0, 8'd0, 0,
              0, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 1, 8'd177, 8'd184, 8'd2, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_RESP, 0, 0, 16'd0, 16'd0),
      dir_row(rrtt_pkg::MODE_RESP, 16'h0002, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_ERROR, 0, 1, 16'd0, 16'd0),
      // broadcast completes on confirmation, hold-off blocks the next request
      dir_row(rrtt_pkg::MODE_REQ, 16'h00FF, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_WAIT_CONF, 1, 0, 16'd500, 16'd0),
      dir_row(rrtt_pkg::MODE_CONF, 16'h0000, 16'h0000, 1, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_OK, 0, 1, 16'd0, 16'd100),
      dir_row(rrtt_pkg::MODE_REQ, 16'h0003, 16'h0005, 0, 8'd0, 8'd0, 8'd0, 0,
              1, rrtt_pkg::PH_OK, 0, 0, 16'd0, 16'd100),
      dir_row(rrtt_pkg::MODE_TICK, 16'h0000, 16'h0000, 0, 8'd0, 8'd0, 8'd0, 0,
              0, rrtt_pkg::PH_IDLE, 0, 0, 16'd0, 16'd0)
    };

    node_plan = '{8'd0, 8'd1, 8'd2, 8'd0, 8'd255, 8'd239};
    node_plan[3] = 8'($urandom_range(0, 3));
    budget = '{280, 280, 280, 280, 40, 40};

    // Synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_node_count(8'd0);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random phases, node_count rewritten only while nothing is in flight
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_node_count(node_plan[ph]);
      phase_sent = 0;
      while (phase_sent < budget[ph]) begin
        if ($urandom_range(0, 99) == 0)
          drain_results();
        send_item(pick_item(), 1'b0, '0);
        phase_sent = phase_sent + 1;
      end
      drain_results();
    end

    if (fail_count == 0 && expected_status.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/rrtt_pkg.sv
rtl/rrtt_if.sv
rtl/rrtt_mac.sv
rtl/request_response_timeout_tracker_core.sv
rtl/rrtt_checker.sv
dv/testbench.sv
